FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rhc_pkg.sv
package rhc_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W = 15;
	localparam int PCT_W = 14;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int PCT_FRAC_BITS_DEF = 7;

	localparam int DEG_FULL = 360;
	localparam int DEG_GREEN = 120;
	localparam int DEG_BLUE = 240;
	localparam int DEG_SECTOR = 60;
	localparam int PCT_FULL = 100;
	localparam int CHAN_MAX = 255;

	// integer bits of the largest hue and percent quotients (below 512 and 128)
	localparam int HUE_INT_BITS = 9;
	localparam int PCT_INT_BITS = 7;
	localparam int HUE_BASE_W = 17;
	localparam int DEG_W = 9;

	localparam int LANES = 3;
	localparam int LANE_HUE = 0;
	localparam int LANE_SAT = 1;
	localparam int LANE_VAL = 2;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	function automatic int div_steps(input int hue_frac, input int pct_frac);
		int h;
		int p;
		h = HUE_INT_BITS + hue_frac;
		p = PCT_INT_BITS + pct_frac;
		return (h > p) ? h : p;
	endfunction

	localparam int STEPS_DEF = div_steps(HUE_FRAC_BITS_DEF, PCT_FRAC_BITS_DEF);

endpackage

FILE: rtl/rhc_prep.sv
module rhc_prep #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int PERCENT_FRAC_BITS = rhc_pkg::PCT_FRAC_BITS_DEF,
	parameter int NSTEP = rhc_pkg::STEPS_DEF,
	localparam int LW = 1 + 2 * rhc_pkg::CHAN_W + NSTEP
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rhc_pkg::CHAN_W-1:0] red,
	input  logic [rhc_pkg::CHAN_W-1:0] green,
	input  logic [rhc_pkg::CHAN_W-1:0] blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [LW-1:0]              out_lane [rhc_pkg::LANES]
);
	import rhc_pkg::*;

	localparam int NW = NSTEP + CHAN_W;

	typedef struct packed {
		logic              zero;
		logic [CHAN_W-1:0] div;
		logic [CHAN_W-1:0] rem;
		logic [NSTEP-1:0]  lq;
	} lane_t;

	logic              v_s1;
	logic [CHAN_W-1:0] cmax_s1;
	logic [CHAN_W-1:0] diff_s1;
	sector_t           sect_s1;
	logic [CHAN_W-1:0] pos_s1;
	logic [CHAN_W-1:0] neg_s1;
	logic              v_s2;
	lane_t             lane_s2 [LANES];

	logic              rdy_s1;
	logic              rdy_s2;
	logic [CHAN_W-1:0] cmax;
	logic [CHAN_W-1:0] cmin;
	sector_t           sect;
	logic [CHAN_W-1:0] pos;
	logic [CHAN_W-1:0] neg;
	logic [DEG_W-1:0]  offset;
	logic [HUE_BASE_W-1:0] hue_base;
	logic [NW-1:0]     hue_num;
	logic [NW-1:0]     sat_num;
	logic [NW-1:0]     val_num;
	lane_t             lane_nx [LANES];

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s2;

	always_comb begin
		cmax = red;
		cmin = red;
		if (green > cmax) cmax = green;
		if (blue > cmax) cmax = blue;
		if (green < cmin) cmin = green;
		if (blue < cmin) cmin = blue;
		if (red >= green && red >= blue) begin
			sect = SECT_RED;
		end else if (green >= blue) begin
			sect = SECT_GREEN;
		end else begin
			sect = SECT_BLUE;
		end
		unique case (sect)
			SECT_RED: begin
				pos = green;
				neg = blue;
			end
			SECT_GREEN: begin
				pos = blue;
				neg = red;
			end
			SECT_BLUE: begin
				pos = red;
				neg = green;
			end
			default: begin
				pos = '0;
				neg = '0;
			end
		endcase
	end

	always_comb begin
		unique case (sect_s1)
			SECT_RED:   offset = DEG_W'(DEG_FULL);
			SECT_GREEN: offset = DEG_W'(DEG_GREEN);
			SECT_BLUE:  offset = DEG_W'(DEG_BLUE);
			default:    offset = '0;
		endcase
		hue_base = HUE_BASE_W'(offset) * HUE_BASE_W'(diff_s1)
			+ HUE_BASE_W'(DEG_SECTOR) * HUE_BASE_W'(pos_s1)
			- HUE_BASE_W'(DEG_SECTOR) * HUE_BASE_W'(neg_s1);
		hue_num = NW'(hue_base) << HUE_FRAC_BITS;
		sat_num = (NW'(PCT_FULL) * NW'(diff_s1)) << PERCENT_FRAC_BITS;
		val_num = (NW'(PCT_FULL) * NW'(cmax_s1)) << PERCENT_FRAC_BITS;

		lane_nx[LANE_HUE].zero = (diff_s1 == '0);
		lane_nx[LANE_HUE].div  = diff_s1;
		lane_nx[LANE_HUE].rem  = hue_num[NW-1:NSTEP];
		lane_nx[LANE_HUE].lq   = hue_num[NSTEP-1:0];
		lane_nx[LANE_SAT].zero = (cmax_s1 == '0);
		lane_nx[LANE_SAT].div  = cmax_s1;
		lane_nx[LANE_SAT].rem  = sat_num[NW-1:NSTEP];
		lane_nx[LANE_SAT].lq   = sat_num[NSTEP-1:0];
		lane_nx[LANE_VAL].zero = 1'b0;
		lane_nx[LANE_VAL].div  = CHAN_W'(CHAN_MAX);
		lane_nx[LANE_VAL].rem  = val_num[NW-1:NSTEP];
		lane_nx[LANE_VAL].lq   = val_num[NSTEP-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			cmax_s1 <= cmax;
			diff_s1 <= cmax - cmin;
			sect_s1 <= sect;
			pos_s1  <= pos;
			neg_s1  <= neg;
		end
		if (v_s1 && rdy_s2) begin
			lane_s2 <= lane_nx;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			out_lane[i] = lane_s2[i];
		end
	end

endmodule

FILE: rtl/rhc_div_cell.sv
`include "assert_macros.svh"

module rhc_div_cell #(
	parameter int NSTEP = rhc_pkg::STEPS_DEF,
	localparam int LW = 1 + 2 * rhc_pkg::CHAN_W + NSTEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  logic [LW-1:0] up_lane [rhc_pkg::LANES],
	output logic          dn_valid,
	input  logic          dn_ready,
	output logic [LW-1:0] dn_lane [rhc_pkg::LANES]
);
	import rhc_pkg::*;

	typedef struct packed {
		logic              zero;
		logic [CHAN_W-1:0] div;
		logic [CHAN_W-1:0] rem;
		logic [NSTEP-1:0]  lq;
	} lane_t;

	logic          valid_q;
	lane_t         lane_q [LANES];
	lane_t         cur [LANES];
	lane_t         nxt [LANES];
	logic [CHAN_W:0] trial [LANES];
	logic [CHAN_W:0] diff [LANES];
	logic          ge [LANES];

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;

	// one restoring step: bring down the next numerator bit, subtract if it fits
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			cur[i]   = lane_t'(up_lane[i]);
			trial[i] = {cur[i].rem, cur[i].lq[NSTEP-1]};
			diff[i]  = trial[i] - {1'b0, cur[i].div};
			ge[i]    = (trial[i] >= {1'b0, cur[i].div});
			nxt[i]   = cur[i];
			nxt[i].rem = ge[i] ? diff[i][CHAN_W-1:0] : trial[i][CHAN_W-1:0];
			nxt[i].lq  = {cur[i].lq[NSTEP-2:0], ge[i]};
			dn_lane[i] = lane_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			lane_q <= nxt;
		end
	end

	`ASSERT_IMPL(a_hue_rem_bound, valid_q && !lane_q[LANE_HUE].zero, lane_q[LANE_HUE].rem < lane_q[LANE_HUE].div, "hue remainder not below divisor")
	`ASSERT_IMPL(a_sat_rem_bound, valid_q && !lane_q[LANE_SAT].zero, lane_q[LANE_SAT].rem < lane_q[LANE_SAT].div, "saturation remainder not below divisor")
	`ASSERT_IMPL(a_val_rem_bound, valid_q, lane_q[LANE_VAL].rem < lane_q[LANE_VAL].div, "value remainder not below divisor")
	`ASSERT_NEXT(a_hold_stalled, valid_q && !dn_ready, valid_q, "stalled transaction dropped from cell")

endmodule

FILE: rtl/rhc_post.sv
module rhc_post #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int NSTEP = rhc_pkg::STEPS_DEF,
	localparam int LW = 1 + 2 * rhc_pkg::CHAN_W + NSTEP
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [LW-1:0]             in_lane [rhc_pkg::LANES],
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rhc_pkg::HUE_W-1:0] hue_out,
	output logic [rhc_pkg::PCT_W-1:0] saturation_out,
	output logic [rhc_pkg::PCT_W-1:0] value_out
);
	import rhc_pkg::*;

	localparam int QW = (NSTEP > HUE_W) ? NSTEP : HUE_W;
	localparam logic [NSTEP-1:0] HUE_WRAP = NSTEP'(DEG_FULL) << HUE_FRAC_BITS;

	typedef struct packed {
		logic              zero;
		logic [CHAN_W-1:0] div;
		logic [CHAN_W-1:0] rem;
		logic [NSTEP-1:0]  lq;
	} lane_t;

	logic             valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q;
	logic [PCT_W-1:0] val_q;

	lane_t            lh;
	lane_t            ls;
	lane_t            lv;
	logic [NSTEP-1:0] hue_w;
	logic [QW-1:0]    hue_x;
	logic [QW-1:0]    sat_x;
	logic [QW-1:0]    val_x;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign hue_out = hue_q;
	assign saturation_out = sat_q;
	assign value_out = val_q;

	always_comb begin
		lh = lane_t'(in_lane[LANE_HUE]);
		ls = lane_t'(in_lane[LANE_SAT]);
		lv = lane_t'(in_lane[LANE_VAL]);
		if (lh.zero) begin
			hue_w = '0;
		end else if (lh.lq >= HUE_WRAP) begin
			hue_w = lh.lq - HUE_WRAP;
		end else begin
			hue_w = lh.lq;
		end
		hue_x = QW'(hue_w);
		sat_x = ls.zero ? '0 : QW'(ls.lq);
		val_x = QW'(lv.lq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hue_q <= hue_x[HUE_W-1:0];
			sat_q <= sat_x[PCT_W-1:0];
			val_q <= val_x[PCT_W-1:0];
		end
	end

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// Pipeline: two setup stages, one divider cell per quotient bit, output register.
// Throughput: one pixel per cycle unless m_tready stalls the chain;
// each divider cell retires one quotient bit per lane.
// Ready ripples back through the cell chain, so bubbles collapse under backpressure.
// Reset: arst_n clears all valid flags at once; payload registers keep no reset value.
module rgb_to_hsv_converter #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int PERCENT_FRAC_BITS = rhc_pkg::PCT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rhc_pkg::S_TDATA_W-1:0] s_tdata,  // red_in, green_in, blue_in
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rhc_pkg::M_TDATA_W-1:0] m_tdata   // hue_out, saturation_out, value_out, pad
);
	import rhc_pkg::*;

	localparam int NSTEP = div_steps(HUE_FRAC_BITS, PERCENT_FRAC_BITS);
	localparam int LW = 1 + 2 * CHAN_W + NSTEP;

	logic          valid [NSTEP+1];
	logic          ready [NSTEP+1];
	logic [LW-1:0] lane [NSTEP+1][LANES];

	logic [HUE_W-1:0] hue_out;
	logic [PCT_W-1:0] saturation_out;
	logic [PCT_W-1:0] value_out;

	rhc_prep #(
		.HUE_FRAC_BITS     (HUE_FRAC_BITS),
		.PERCENT_FRAC_BITS (PERCENT_FRAC_BITS),
		.NSTEP             (NSTEP)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[CHAN_W-1:0]),
		.green     (s_tdata[2*CHAN_W-1:CHAN_W]),
		.blue      (s_tdata[3*CHAN_W-1:2*CHAN_W]),
		.out_valid (valid[0]),
		.out_ready (ready[0]),
		.out_lane  (lane[0])
	);

	for (genvar k = 0; k < NSTEP; k++) begin : g_cell
		rhc_div_cell #(
			.NSTEP (NSTEP)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid[k]),
			.up_ready (ready[k]),
			.up_lane  (lane[k]),
			.dn_valid (valid[k+1]),
			.dn_ready (ready[k+1]),
			.dn_lane  (lane[k+1])
		);
	end

	rhc_post #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.NSTEP         (NSTEP)
	) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (valid[NSTEP]),
		.in_ready       (ready[NSTEP]),
		.in_lane        (lane[NSTEP]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.hue_out        (hue_out),
		.saturation_out (saturation_out),
		.value_out      (value_out)
	);

	assign m_tdata = M_TDATA_W'({value_out, saturation_out, hue_out});

endmodule
